// ----- hdl/iqgf_pkg.sv -----
// ----------------------------------------------------------------------------
// iqgf_pkg: shared types, constants and micro-program of the gravity fusion block
// Holds the datapath widths, the operand, shift and destination codes and the
// micro-op table that the sequencer steps through for one sample.
// ----------------------------------------------------------------------------
package iqgf_pkg;

	localparam int QuatFrac   = 30;
	localparam int SampleFrac = 16;
	localparam int GainFrac   = 16;
	localparam int RateShift  = 32;
	localparam int DeltaShift = SampleFrac + 25 - QuatFrac;
	localparam int NormHi     = 30;
	localparam int NormLo     = 29;

	localparam int OW  = 35;  // multiplier operand
	localparam int PW  = 2 * OW;
	localparam int AW  = 66;  // accumulator
	localparam int CW  = 35;  // wide intermediates
	localparam int PcW = 7;

	localparam logic [PcW-1:0] PcQuatSq = 7'd24;
	localparam logic [PcW-1:0] PcAccel  = 7'd33;

	localparam logic signed [OW-1:0] DegToRad = 35'sd74961321;
	localparam logic signed [OW-1:0] QOne     = OW'(64'sd1 << QuatFrac);
	localparam logic signed [31:0]   QOne32   = 32'(64'sd1 << QuatFrac);
	localparam logic signed [AW-1:0] SatHi    = AW'(64'sd2147483647);
	localparam logic signed [AW-1:0] SatLo    = AW'(-64'sd2147483648);
	localparam logic [15:0]          GainRst  = 16'd1311;

	typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_ACC, ST_NORM, ST_ITER} state_t;

	typedef enum logic [2:0] {K_MUL, K_MAGC, K_NORM, K_ROOT, K_DIV, K_MAT, K_END} kind_t;

	typedef enum logic [5:0] {
		O_G0, O_G1, O_G2, O_DEG, O_R, O_DT,
		O_Q0, O_Q1, O_Q2, O_Q3, O_D0, O_D1, O_D2, O_ONE,
		O_MG0, O_MG1, O_MG2, O_MG3, O_AM0, O_AM1, O_AM2,
		O_A0, O_A1, O_A2, O_N0, O_N1, O_N2, O_GR0, O_GR1, O_GR2,
		O_E0, O_E1, O_E2, O_GAIN,
		O_M0, O_M1, O_M2, O_M3, O_M4, O_M5, O_M6, O_M7, O_M8
	} opnd_t;

	typedef enum logic [2:0] {SH_0, SH_Q, SH_RATE, SH_DELTA, SH_GAIN} shift_t;

	typedef enum logic [4:0] {
		D_NONE, D_R, D_D0, D_D1, D_D2, D_C0, D_C1, D_C2, D_C3,
		D_PB0, D_PB1, D_PB2, D_PB3, D_PB4, D_PB5, D_PB6, D_PB7, D_PB8, D_PB9,
		D_E0, D_E1, D_E2, D_Q0, D_Q1, D_Q2, D_Q3, D_W0, D_W1, D_W2,
		D_N0, D_N1, D_N2
	} dst_t;

	typedef struct packed {
		kind_t  kind;
		opnd_t  a;
		opnd_t  b;
		shift_t sh;
		logic   fresh;
		logic   neg;
		dst_t   dst;
	} uop_t;

	typedef struct packed {
		logic take_in;
		logic mul_go;
		logic acc_go;
		logic mag_go;
		logic mat_go;
		logic unit_go;
		logic unit_wr;
		logic nzero_wr;
		logic out_load;
	} ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
		logic signed [31:0] r;
		if (v > SatHi)
			r = 32'sh7fffffff;
		else if (v < SatLo)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic uop_t mu(input opnd_t a, input opnd_t b, input shift_t sh,
			input logic fresh, input logic neg, input dst_t dst);
		uop_t u;
		u.kind  = K_MUL;
		u.a     = a;
		u.b     = b;
		u.sh    = sh;
		u.fresh = fresh;
		u.neg   = neg;
		u.dst   = dst;
		return u;
	endfunction

	function automatic uop_t cu(input kind_t k, input opnd_t a, input dst_t dst);
		uop_t u;
		u.kind  = k;
		u.a     = a;
		u.b     = O_ONE;
		u.sh    = SH_0;
		u.fresh = 1'b0;
		u.neg   = 1'b0;
		u.dst   = dst;
		return u;
	endfunction

	// one sample: gyro delta, quaternion product, renormalize, accel normalize,
	// gravity error, drift correction, world-frame rotation
	function automatic uop_t uop_rom(input logic [PcW-1:0] pc);
		uop_t u;
		unique case (pc)
			7'd0:  u = mu(O_G0, O_DEG, SH_RATE, 1'b1, 1'b0, D_R);
			7'd1:  u = mu(O_R, O_DT, SH_DELTA, 1'b1, 1'b0, D_D0);
			7'd2:  u = mu(O_G1, O_DEG, SH_RATE, 1'b1, 1'b0, D_R);
			7'd3:  u = mu(O_R, O_DT, SH_DELTA, 1'b1, 1'b0, D_D1);
			7'd4:  u = mu(O_G2, O_DEG, SH_RATE, 1'b1, 1'b0, D_R);
			7'd5:  u = mu(O_R, O_DT, SH_DELTA, 1'b1, 1'b0, D_D2);
			7'd6:  u = mu(O_Q0, O_ONE, SH_Q, 1'b1, 1'b0, D_NONE);
			7'd7:  u = mu(O_Q1, O_D0, SH_Q, 1'b0, 1'b1, D_NONE);
			7'd8:  u = mu(O_Q2, O_D1, SH_Q, 1'b0, 1'b1, D_NONE);
			7'd9:  u = mu(O_Q3, O_D2, SH_Q, 1'b0, 1'b1, D_C0);
			7'd10: u = mu(O_Q1, O_ONE, SH_Q, 1'b1, 1'b0, D_NONE);
			7'd11: u = mu(O_Q0, O_D0, SH_Q, 1'b0, 1'b0, D_NONE);
			7'd12: u = mu(O_Q2, O_D2, SH_Q, 1'b0, 1'b0, D_NONE);
			7'd13: u = mu(O_Q3, O_D1, SH_Q, 1'b0, 1'b1, D_C1);
			7'd14: u = mu(O_Q2, O_ONE, SH_Q, 1'b1, 1'b0, D_NONE);
			7'd15: u = mu(O_Q0, O_D1, SH_Q, 1'b0, 1'b0, D_NONE);
			7'd16: u = mu(O_Q1, O_D2, SH_Q, 1'b0, 1'b1, D_NONE);
			7'd17: u = mu(O_Q3, O_D0, SH_Q, 1'b0, 1'b0, D_C2);
			7'd18: u = mu(O_Q3, O_ONE, SH_Q, 1'b1, 1'b0, D_NONE);
			7'd19: u = mu(O_Q0, O_D2, SH_Q, 1'b0, 1'b0, D_NONE);
			7'd20: u = mu(O_Q1, O_D1, SH_Q, 1'b0, 1'b0, D_NONE);
			7'd21: u = mu(O_Q2, O_D0, SH_Q, 1'b0, 1'b1, D_C3);
			7'd22: u = cu(K_MAGC, O_ONE, D_NONE);
			7'd23: u = cu(K_NORM, O_ONE, D_NONE);
			7'd24: u = mu(O_MG0, O_MG0, SH_0, 1'b1, 1'b0, D_NONE);
			7'd25: u = mu(O_MG1, O_MG1, SH_0, 1'b0, 1'b0, D_NONE);
			7'd26: u = mu(O_MG2, O_MG2, SH_0, 1'b0, 1'b0, D_NONE);
			7'd27: u = mu(O_MG3, O_MG3, SH_0, 1'b0, 1'b0, D_NONE);
			7'd28: u = cu(K_ROOT, O_ONE, D_NONE);
			7'd29: u = cu(K_DIV, O_MG0, D_Q0);
			7'd30: u = cu(K_DIV, O_MG1, D_Q1);
			7'd31: u = cu(K_DIV, O_MG2, D_Q2);
			7'd32: u = cu(K_DIV, O_MG3, D_Q3);
			7'd33: u = mu(O_AM0, O_AM0, SH_0, 1'b1, 1'b0, D_NONE);
			7'd34: u = mu(O_AM1, O_AM1, SH_0, 1'b0, 1'b0, D_NONE);
			7'd35: u = mu(O_AM2, O_AM2, SH_0, 1'b0, 1'b0, D_NONE);
			7'd36: u = cu(K_ROOT, O_ONE, D_NONE);
			7'd37: u = cu(K_DIV, O_AM0, D_N0);
			7'd38: u = cu(K_DIV, O_AM1, D_N1);
			7'd39: u = cu(K_DIV, O_AM2, D_N2);
			7'd40, 7'd63: u = mu(O_Q0, O_Q0, SH_Q, 1'b1, 1'b0, D_PB0);
			7'd41, 7'd64: u = mu(O_Q1, O_Q1, SH_Q, 1'b1, 1'b0, D_PB1);
			7'd42, 7'd65: u = mu(O_Q2, O_Q2, SH_Q, 1'b1, 1'b0, D_PB2);
			7'd43, 7'd66: u = mu(O_Q3, O_Q3, SH_Q, 1'b1, 1'b0, D_PB3);
			7'd44, 7'd67: u = mu(O_Q1, O_Q2, SH_Q, 1'b1, 1'b0, D_PB4);
			7'd45, 7'd68: u = mu(O_Q1, O_Q3, SH_Q, 1'b1, 1'b0, D_PB5);
			7'd46, 7'd69: u = mu(O_Q2, O_Q3, SH_Q, 1'b1, 1'b0, D_PB6);
			7'd47, 7'd70: u = mu(O_Q0, O_Q1, SH_Q, 1'b1, 1'b0, D_PB7);
			7'd48, 7'd71: u = mu(O_Q0, O_Q2, SH_Q, 1'b1, 1'b0, D_PB8);
			7'd49, 7'd72: u = mu(O_Q0, O_Q3, SH_Q, 1'b1, 1'b0, D_PB9);
			7'd50, 7'd73: u = cu(K_MAT, O_ONE, D_NONE);
			7'd51: u = mu(O_N1, O_GR2, SH_Q, 1'b1, 1'b0, D_NONE);
			7'd52: u = mu(O_N2, O_GR1, SH_Q, 1'b0, 1'b1, D_E0);
			7'd53: u = mu(O_N2, O_GR0, SH_Q, 1'b1, 1'b0, D_NONE);
			7'd54: u = mu(O_N0, O_GR2, SH_Q, 1'b0, 1'b1, D_E1);
			7'd55: u = mu(O_N0, O_GR1, SH_Q, 1'b1, 1'b0, D_NONE);
			7'd56: u = mu(O_N1, O_GR0, SH_Q, 1'b0, 1'b1, D_E2);
			7'd57: u = mu(O_Q1, O_ONE, SH_Q, 1'b1, 1'b0, D_NONE);
			7'd58: u = mu(O_E0, O_GAIN, SH_GAIN, 1'b0, 1'b0, D_Q1);
			7'd59: u = mu(O_Q2, O_ONE, SH_Q, 1'b1, 1'b0, D_NONE);
			7'd60: u = mu(O_E1, O_GAIN, SH_GAIN, 1'b0, 1'b0, D_Q2);
			7'd61: u = mu(O_Q3, O_ONE, SH_Q, 1'b1, 1'b0, D_NONE);
			7'd62: u = mu(O_E2, O_GAIN, SH_GAIN, 1'b0, 1'b0, D_Q3);
			7'd74: u = mu(O_M0, O_A0, SH_Q, 1'b1, 1'b0, D_NONE);
			7'd75: u = mu(O_M1, O_A1, SH_Q, 1'b0, 1'b0, D_NONE);
			7'd76: u = mu(O_M2, O_A2, SH_Q, 1'b0, 1'b0, D_W0);
			7'd77: u = mu(O_M3, O_A0, SH_Q, 1'b1, 1'b0, D_NONE);
			7'd78: u = mu(O_M4, O_A1, SH_Q, 1'b0, 1'b0, D_NONE);
			7'd79: u = mu(O_M5, O_A2, SH_Q, 1'b0, 1'b0, D_W1);
			7'd80: u = mu(O_M6, O_A0, SH_Q, 1'b1, 1'b0, D_NONE);
			7'd81: u = mu(O_M7, O_A1, SH_Q, 1'b0, 1'b0, D_NONE);
			7'd82: u = mu(O_M8, O_A2, SH_Q, 1'b0, 1'b0, D_W2);
			default: u = cu(K_END, O_ONE, D_NONE);
		endcase
		return u;
	endfunction

endpackage

// ----- hdl/iqgf_rootdiv.sv -----
// ----------------------------------------------------------------------------
// iqgf_rootdiv: shared iterative square root and divider
// One 64-bit subtract-and-compare per cycle, 32 steps per operation; computes
// floor sqrt of a 64-bit value or a 32-bit quotient of num / den.
// ----------------------------------------------------------------------------
module iqgf_rootdiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        is_root,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        busy,
	output logic        done,
	output logic [31:0] res
);

	logic        busy_q, done_q, root_q;
	logic [4:0]  cnt_q;
	logic [63:0] n_q, r_q, bit_q;
	logic [31:0] rem_q, den_q;
	logic [63:0] lhs, rhs;
	logic [64:0] diff;
	logic        ge;

	// root: n - (res + bit); divide: shifted remainder - den
	assign lhs  = root_q ? n_q : {31'b0, rem_q, n_q[63]};
	assign rhs  = root_q ? (r_q + bit_q) : {32'b0, den_q};
	assign diff = {1'b0, lhs} - {1'b0, rhs};
	assign ge   = ~diff[64];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			root_q <= is_root;
			den_q  <= den;
			r_q    <= '0;
			bit_q  <= 64'h4000_0000_0000_0000;
			if (is_root) begin
				n_q   <= num;
				rem_q <= '0;
			end else begin
				n_q   <= {num[31:0], 32'b0};
				rem_q <= num[63:32];
			end
		end else if (busy_q) begin
			if (root_q) begin
				if (ge) begin
					n_q <= diff[63:0];
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				rem_q <= ge ? diff[31:0] : {rem_q[30:0], n_q[63]};
				n_q   <= n_q << 1;
				r_q   <= {r_q[62:0], ge};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res  = r_q[31:0];

endmodule

// ----- hdl/imu_quaternion_gravity_fusion.sv -----
// ----------------------------------------------------------------------------
// imu_quaternion_gravity_fusion: fixed-point quaternion complementary filter
// Integrates gyro rate into an orientation quaternion, renormalizes it, pulls
// it toward measured gravity and emits the accel rotated into the world frame.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake          payload
//  s_*        in   s_tvalid/s_tready  gyro x,y,z, accel x,y,z, time step
//  m_*        out  m_tvalid/m_tready  world-frame accel x,y,z (saturated)
//  cfg_*      in   cfg_we             correction gain, unsigned Q0.16
//
//  one sample runs 70 multiplies on the shared 35x35 multiplier, nine root/divide runs
//  and a normalizing shift of the quaternion magnitudes from input transfer to result
//  valid; zero accel skips three divides, a zero quaternion its root and divides;
//  s_tready is high only while idle, from the cycle after the result loads; a result
//  waits in the output register, the sequencer holds at its end until that register
//  is free; reset loads the identity quaternion and the default gain
//
module imu_quaternion_gravity_fusion (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [215:0] s_tdata,   // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, time_step
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // world_x, world_y, world_z
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata
);
	import iqgf_pkg::*;

	state_t state_q, state_n;
	ctl_t   ctl;
	uop_t   uop;

	logic [PcW-1:0] pc_q;
	logic [15:0]    gain_q;
	logic           out_valid_q;
	logic           out_free;

	// captured sample
	logic signed [31:0] g_q [3];
	logic signed [31:0] a_q [3];
	logic [23:0]        dt_q;

	// orientation state
	logic signed [31:0] q_q [4];

	// working registers
	logic signed [31:0] r_q;
	logic signed [31:0] d_q [3];
	logic signed [CW-1:0] c_q [4];
	logic [OW-1:0]      mg_q [4];
	logic [3:0]         csgn_q;
	logic [31:0]        s_q;
	logic signed [31:0] n_q [3];
	logic signed [CW-1:0] pb_q [10];
	logic signed [31:0] m_q [9];
	logic signed [CW-1:0] e_q [3];
	logic signed [31:0] w_q [3];
	logic signed [31:0] wo_q [3];

	// multiplier and accumulator
	logic signed [OW-1:0] opr [2];
	logic signed [PW-1:0] p_s1;
	logic signed [AW-1:0] acc_q, acc_n, term, base;

	logic [31:0]        amag [3];
	logic signed [31:0] m_n [9];
	logic [OW-1:0]      mg_or;
	logic               mg_zero, mg_hi, mg_lo;
	logic [63:0]        div_num;
	logic               div_neg;
	logic signed [31:0] div_v;
	logic               rd_busy, rd_done;
	logic [31:0]        rd_res;

	assign uop      = uop_rom(pc_q);
	assign out_free = ~out_valid_q | m_tready;

	// accel magnitudes, full range incl. most negative
	always_comb begin
		for (int k = 0; k < 3; k++)
			amag[k] = a_q[k][31] ? (~a_q[k] + 32'd1) : a_q[k];
	end

	// normalizing window checks on the joint magnitudes
	assign mg_or   = mg_q[0] | mg_q[1] | mg_q[2] | mg_q[3];
	assign mg_zero = (mg_or == '0);
	assign mg_hi   = |mg_or[OW-1:NormHi];
	assign mg_lo   = ~|mg_or[OW-1:NormLo];

	// operand selection for the shared multiplier
	always_comb begin
		opnd_t sel;
		logic signed [OW-1:0] v;
		for (int k = 0; k < 2; k++) begin
			sel = (k == 0) ? uop.a : uop.b;
			unique case (sel)
				O_G0:   v = OW'(g_q[0]);
				O_G1:   v = OW'(g_q[1]);
				O_G2:   v = OW'(g_q[2]);
				O_DEG:  v = DegToRad;
				O_R:    v = OW'(r_q);
				O_DT:   v = $signed({{(OW-24){1'b0}}, dt_q});
				O_Q0:   v = OW'(q_q[0]);
				O_Q1:   v = OW'(q_q[1]);
				O_Q2:   v = OW'(q_q[2]);
				O_Q3:   v = OW'(q_q[3]);
				O_D0:   v = OW'(d_q[0]);
				O_D1:   v = OW'(d_q[1]);
				O_D2:   v = OW'(d_q[2]);
				O_ONE:  v = QOne;
				O_MG0:  v = $signed(mg_q[0]);
				O_MG1:  v = $signed(mg_q[1]);
				O_MG2:  v = $signed(mg_q[2]);
				O_MG3:  v = $signed(mg_q[3]);
				O_AM0:  v = $signed({{(OW-32){1'b0}}, amag[0]});
				O_AM1:  v = $signed({{(OW-32){1'b0}}, amag[1]});
				O_AM2:  v = $signed({{(OW-32){1'b0}}, amag[2]});
				O_A0:   v = OW'(a_q[0]);
				O_A1:   v = OW'(a_q[1]);
				O_A2:   v = OW'(a_q[2]);
				O_N0:   v = OW'(n_q[0]);
				O_N1:   v = OW'(n_q[1]);
				O_N2:   v = OW'(n_q[2]);
				O_GR0:  v = -OW'(m_q[2]);   // gravity is minus the third column
				O_GR1:  v = -OW'(m_q[5]);
				O_GR2:  v = -OW'(m_q[8]);
				O_E0:   v = e_q[0];
				O_E1:   v = e_q[1];
				O_E2:   v = e_q[2];
				O_GAIN: v = $signed({{(OW-16){1'b0}}, gain_q});
				O_M0:   v = OW'(m_q[0]);
				O_M1:   v = OW'(m_q[1]);
				O_M2:   v = OW'(m_q[2]);
				O_M3:   v = OW'(m_q[3]);
				O_M4:   v = OW'(m_q[4]);
				O_M5:   v = OW'(m_q[5]);
				O_M6:   v = OW'(m_q[6]);
				O_M7:   v = OW'(m_q[7]);
				O_M8:   v = OW'(m_q[8]);
				default: v = '0;
			endcase
			opr[k] = v;
		end
	end

	// floor-shift the registered product, then add or subtract
	always_comb begin
		case (uop.sh)
			SH_Q:     term = AW'(p_s1 >>> QuatFrac);
			SH_RATE:  term = AW'(p_s1 >>> RateShift);
			SH_DELTA: term = AW'(p_s1 >>> DeltaShift);
			SH_GAIN:  term = AW'(p_s1 >>> GainFrac);
			default:  term = AW'(p_s1);
		endcase
		base  = uop.fresh ? '0 : acc_q;
		acc_n = uop.neg ? (base - term) : (base + term);
	end

	// rotation matrix from the product bank: ww xx yy zz xy xz yz wx wy wz
	always_comb begin
		m_n[0] = sat32(AW'(pb_q[0]) + AW'(pb_q[1]) - AW'(pb_q[2]) - AW'(pb_q[3]));
		m_n[1] = sat32((AW'(pb_q[4]) - AW'(pb_q[9])) <<< 1);
		m_n[2] = sat32((AW'(pb_q[5]) + AW'(pb_q[8])) <<< 1);
		m_n[3] = sat32((AW'(pb_q[4]) + AW'(pb_q[9])) <<< 1);
		m_n[4] = sat32(AW'(pb_q[0]) - AW'(pb_q[1]) + AW'(pb_q[2]) - AW'(pb_q[3]));
		m_n[5] = sat32((AW'(pb_q[6]) - AW'(pb_q[7])) <<< 1);
		m_n[6] = sat32((AW'(pb_q[5]) - AW'(pb_q[8])) <<< 1);
		m_n[7] = sat32((AW'(pb_q[6]) + AW'(pb_q[7])) <<< 1);
		m_n[8] = sat32(AW'(pb_q[0]) - AW'(pb_q[1]) - AW'(pb_q[2]) + AW'(pb_q[3]));
	end

	// divider numerator (magnitude << Q) and sign of the quotient
	always_comb begin
		case (uop.a)
			O_MG0:   begin div_num = 64'(mg_q[0]) << QuatFrac; div_neg = csgn_q[0]; end
			O_MG1:   begin div_num = 64'(mg_q[1]) << QuatFrac; div_neg = csgn_q[1]; end
			O_MG2:   begin div_num = 64'(mg_q[2]) << QuatFrac; div_neg = csgn_q[2]; end
			O_MG3:   begin div_num = 64'(mg_q[3]) << QuatFrac; div_neg = csgn_q[3]; end
			O_AM0:   begin div_num = 64'(amag[0]) << QuatFrac; div_neg = a_q[0][31]; end
			O_AM1:   begin div_num = 64'(amag[1]) << QuatFrac; div_neg = a_q[1][31]; end
			O_AM2:   begin div_num = 64'(amag[2]) << QuatFrac; div_neg = a_q[2][31]; end
			default: begin div_num = acc_q[63:0]; div_neg = 1'b0; end
		endcase
		// quotient never exceeds one in Q fraction
		div_v = div_neg ? -$signed(rd_res) : $signed(rd_res);
	end

	iqgf_rootdiv u_rootdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.unit_go),
		.is_root (uop.kind == K_ROOT),
		.num     (uop.kind == K_ROOT ? acc_q[63:0] : div_num),
		.den     (s_q),
		.busy    (rd_busy),
		.done    (rd_done),
		.res     (rd_res)
	);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_n = ST_RUN;
			ST_RUN: begin
				case (uop.kind)
					K_MUL:  state_n = ST_ACC;
					K_NORM: state_n = ST_NORM;
					K_ROOT: state_n = ST_ITER;
					K_DIV:  if (s_q != '0) state_n = ST_ITER;
					K_END:  if (out_free) state_n = ST_IDLE;
					default: state_n = ST_RUN;
				endcase
			end
			ST_ACC: state_n = ST_RUN;
			ST_NORM: if (mg_zero || (!mg_hi && !mg_lo)) state_n = ST_RUN;
			ST_ITER: if (rd_done) state_n = ST_RUN;
			default: state_n = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_IDLE: ctl.take_in = s_tvalid;
			ST_RUN: begin
				ctl.mul_go   = (uop.kind == K_MUL);
				ctl.mag_go   = (uop.kind == K_MAGC);
				ctl.mat_go   = (uop.kind == K_MAT);
				ctl.unit_go  = (uop.kind == K_ROOT) || ((uop.kind == K_DIV) && (s_q != '0));
				ctl.nzero_wr = (uop.kind == K_DIV) && (s_q == '0);
				ctl.out_load = (uop.kind == K_END) && out_free;
			end
			ST_ACC:  ctl.acc_go = 1'b1;
			ST_ITER: ctl.unit_wr = rd_done;
			default: ctl = '0;
		endcase
	end

	// control, gain and orientation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			gain_q      <= GainRst;
			out_valid_q <= 1'b0;
			q_q[0]      <= QOne32;
			q_q[1]      <= '0;
			q_q[2]      <= '0;
			q_q[3]      <= '0;
		end else begin
			state_q <= state_n;
			if (cfg_we)
				gain_q <= cfg_wdata;

			if (ctl.out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			// program counter
			if (ctl.take_in)
				pc_q <= '0;
			else if (ctl.acc_go || ctl.unit_wr || ctl.mag_go || ctl.mat_go || ctl.nzero_wr)
				pc_q <= pc_q + PcW'(1);
			else if (state_q == ST_NORM && mg_zero)
				pc_q <= PcAccel;
			else if (state_q == ST_NORM && !mg_hi && !mg_lo)
				pc_q <= pc_q + PcW'(1);

			// quaternion writes: drift correction, renormalize, zero fallback
			for (int k = 0; k < 4; k++) begin
				if (ctl.acc_go && uop.dst == dst_t'(int'(D_Q0) + k))
					q_q[k] <= sat32(acc_n);
				if (ctl.unit_wr && uop.kind == K_DIV && uop.dst == dst_t'(int'(D_Q0) + k))
					q_q[k] <= div_v;
			end
			if (state_q == ST_NORM && mg_zero) begin
				q_q[0] <= QOne32;
				q_q[1] <= '0;
				q_q[2] <= '0;
				q_q[3] <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (ctl.take_in) begin
			for (int k = 0; k < 3; k++) begin
				g_q[k] <= s_tdata[32*k +: 32];
				a_q[k] <= s_tdata[96 + 32*k +: 32];
			end
			dt_q <= s_tdata[215:192];
		end

		if (ctl.mul_go)
			p_s1 <= opr[0] * opr[1];

		if (ctl.acc_go) begin
			acc_q <= acc_n;
			if (uop.dst == D_R)
				r_q <= acc_n[31:0];
			for (int k = 0; k < 3; k++) begin
				if (uop.dst == dst_t'(int'(D_D0) + k)) d_q[k] <= sat32(acc_n);
				if (uop.dst == dst_t'(int'(D_E0) + k)) e_q[k] <= acc_n[CW-1:0];
				if (uop.dst == dst_t'(int'(D_W0) + k)) w_q[k] <= sat32(acc_n);
			end
			for (int k = 0; k < 4; k++)
				if (uop.dst == dst_t'(int'(D_C0) + k)) c_q[k] <= acc_n[CW-1:0];
			for (int k = 0; k < 10; k++)
				if (uop.dst == dst_t'(int'(D_PB0) + k)) pb_q[k] <= acc_n[CW-1:0];
		end

		if (ctl.mag_go) begin
			for (int k = 0; k < 4; k++) begin
				mg_q[k]   <= c_q[k][CW-1] ? OW'(-c_q[k]) : OW'(c_q[k]);
				csgn_q[k] <= c_q[k][CW-1];
			end
		end

		// joint shift until the largest magnitude sits in [2^29, 2^30)
		if (state_q == ST_NORM && !mg_zero) begin
			for (int k = 0; k < 4; k++) begin
				if (mg_hi)
					mg_q[k] <= mg_q[k] >> 1;
				else if (mg_lo)
					mg_q[k] <= mg_q[k] << 1;
			end
		end

		if (ctl.mat_go)
			m_q <= m_n;

		if (ctl.unit_wr) begin
			if (uop.kind == K_ROOT)
				s_q <= rd_res;
			for (int k = 0; k < 3; k++)
				if (uop.kind == K_DIV && uop.dst == dst_t'(int'(D_N0) + k)) n_q[k] <= div_v;
		end

		// zero accel: no normalization, no correction
		if (ctl.nzero_wr) begin
			for (int k = 0; k < 3; k++)
				if (uop.dst == dst_t'(int'(D_N0) + k)) n_q[k] <= '0;
		end

		if (ctl.out_load)
			wo_q <= w_q;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {wo_q[2], wo_q[1], wo_q[0]};

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_RUN && pc_q == '0)
		else $error("sample transfer did not restart the sequencer");

	a_unit_in_iter: assert property (@(posedge clk) disable iff (!arst_n)
		rd_busy |-> state_q == ST_ITER)
		else $error("root/divide unit busy outside its wait state");

	a_norm_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && pc_q == PcQuatSq |-> mg_or[OW-1:NormLo] == (OW-NormLo)'(1))
		else $error("quaternion magnitudes left the normalizing window");

	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_RUN && $past(uop.kind) == K_END)
		else $error("result presented before the program finished");
`endif

endmodule

// ----- test/imu_quaternion_gravity_fusion_chk.sv -----
// ----------------------------------------------------------------------------
// imu_quaternion_gravity_fusion_chk: scoreboard for the gravity fusion block
// Tracks the gain register and the orientation quaternion, predicts the
// world-frame accel of every input transfer and compares output transfers.
// ----------------------------------------------------------------------------
module imu_quaternion_gravity_fusion_chk (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [215:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [95:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	output int           fail_count,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import iqgf_pkg::*;

	localparam longint DegQ32 = 64'sd74961321;

	logic [15:0]  gain_reg;
	longint       qw, qx, qy, qz;
	longint       mtx [9];
	logic [95:0]  world_q [$];

	function automatic longint mul_q(input longint a, input longint b);
		return (a * b) >>> QuatFrac;
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned root64(input longint unsigned n);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (n >= res + bt) begin
				n = n - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned mag(input longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// magnitude divided, sign of the numerator source restored
	function automatic longint sdiv(input longint src, input longint unsigned num,
			input longint unsigned den);
		longint r;
		r = longint'(num / den);
		return src < 0 ? -r : r;
	endfunction

	function automatic void fill_mtx();
		longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
		ww = mul_q(qw, qw); xx = mul_q(qx, qx); yy = mul_q(qy, qy); zz = mul_q(qz, qz);
		xy = mul_q(qx, qy); xz = mul_q(qx, qz); yz = mul_q(qy, qz);
		wx = mul_q(qw, qx); wy = mul_q(qw, qy); wz = mul_q(qw, qz);
		mtx[0] = clip32(ww + xx - yy - zz);
		mtx[1] = clip32(2 * (xy - wz));
		mtx[2] = clip32(2 * (xz + wy));
		mtx[3] = clip32(2 * (xy + wz));
		mtx[4] = clip32(ww - xx + yy - zz);
		mtx[5] = clip32(2 * (yz - wx));
		mtx[6] = clip32(2 * (xz - wy));
		mtx[7] = clip32(2 * (yz + wx));
		mtx[8] = clip32(ww - xx - yy + zz);
	endfunction

	function automatic void renorm(input longint c [4]);
		longint unsigned mg [4];
		longint unsigned mx, sum, s;
		mx = 0;
		sum = 0;
		for (int i = 0; i < 4; i++) begin
			mg[i] = mag(c[i]);
			if (mg[i] > mx)
				mx = mg[i];
		end
		if (mx == 0) begin
			// degenerate quaternion falls back to identity
			qw = 64'sd1 << QuatFrac;
			qx = 0; qy = 0; qz = 0;
			return;
		end
		while (mx >= (64'd1 << NormHi)) begin
			mx = mx >> 1;
			for (int i = 0; i < 4; i++) mg[i] = mg[i] >> 1;
		end
		while (mx < (64'd1 << NormLo)) begin
			mx = mx << 1;
			for (int i = 0; i < 4; i++) mg[i] = mg[i] << 1;
		end
		for (int i = 0; i < 4; i++) sum = sum + mg[i] * mg[i];
		s = root64(sum);
		qw = clip32(sdiv(c[0], mg[0] << QuatFrac, s));
		qx = clip32(sdiv(c[1], mg[1] << QuatFrac, s));
		qy = clip32(sdiv(c[2], mg[2] << QuatFrac, s));
		qz = clip32(sdiv(c[3], mg[3] << QuatFrac, s));
	endfunction

	function automatic logic [95:0] fuse_sample(input logic [215:0] d);
		longint g [3], a [3], dl [3], n [3], gr [3], e [3];
		longint c [4];
		longint dt, r, w, x, y, z, v;
		longint unsigned sum, am;
		logic [95:0] res;
		sum = 0;
		dt = longint'(d[215:192]);
		for (int i = 0; i < 3; i++) begin
			g[i] = longint'($signed(d[32*i +: 32]));
			a[i] = longint'($signed(d[96 + 32*i +: 32]));
		end
		for (int i = 0; i < 3; i++) begin
			r = (g[i] * DegQ32) >>> RateShift;
			dl[i] = clip32((r * dt) >>> DeltaShift);
		end
		w = qw; x = qx; y = qy; z = qz;
		c[0] = w - mul_q(x, dl[0]) - mul_q(y, dl[1]) - mul_q(z, dl[2]);
		c[1] = x + mul_q(w, dl[0]) + mul_q(y, dl[2]) - mul_q(z, dl[1]);
		c[2] = y + mul_q(w, dl[1]) - mul_q(x, dl[2]) + mul_q(z, dl[0]);
		c[3] = z + mul_q(w, dl[2]) + mul_q(x, dl[1]) - mul_q(y, dl[0]);
		renorm(c);
		for (int i = 0; i < 3; i++) sum = sum + mag(a[i]) * mag(a[i]);
		am = root64(sum);
		// zero accel skips normalization and so the correction
		for (int i = 0; i < 3; i++)
			n[i] = (am != 0) ? sdiv(a[i], mag(a[i]) << QuatFrac, am) : 0;
		fill_mtx();
		gr[0] = -mtx[2]; gr[1] = -mtx[5]; gr[2] = -mtx[8];
		e[0] = mul_q(n[1], gr[2]) - mul_q(n[2], gr[1]);
		e[1] = mul_q(n[2], gr[0]) - mul_q(n[0], gr[2]);
		e[2] = mul_q(n[0], gr[1]) - mul_q(n[1], gr[0]);
		qx = clip32(qx + ((e[0] * longint'(gain_reg)) >>> GainFrac));
		qy = clip32(qy + ((e[1] * longint'(gain_reg)) >>> GainFrac));
		qz = clip32(qz + ((e[2] * longint'(gain_reg)) >>> GainFrac));
		fill_mtx();
		for (int i = 0; i < 3; i++) begin
			v = mul_q(mtx[3*i], a[0]) + mul_q(mtx[3*i+1], a[1]) + mul_q(mtx[3*i+2], a[2]);
			res[32*i +: 32] = 32'(clip32(v));
		end
		return res;
	endfunction

	assign pending = world_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [95:0] exp_w;
		string nm;
		if (!arst_n) begin
			gain_reg = GainRst;
			qw = 64'sd1 << QuatFrac;
			qx = 0; qy = 0; qz = 0;
			fail_count = 0;
			world_q.delete();
		end else begin
			if (cfg_we)
				gain_reg = cfg_wdata;
			if (s_tvalid && s_tready)
				world_q.push_back(fuse_sample(s_tdata));
			if (m_tvalid && m_tready) begin
				if (world_q.size() == 0) begin
					$error("output transfer with nothing expected: %h", m_tdata);
					fail_count++;
				end else begin
					exp_w = world_q.pop_front();
					for (int i = 0; i < 3; i++) begin
						nm = (i == 0) ? "world_x" : (i == 1) ? "world_y" : "world_z";
						if (m_tdata[32*i +: 32] !== exp_w[32*i +: 32]) begin
							$error("%s expected %0d actual %0d", nm,
								$signed(exp_w[32*i +: 32]), $signed(m_tdata[32*i +: 32]));
							fail_count++;
						end
					end
				end
			end
		end
	end

endmodule

// ----- test/imu_quaternion_gravity_fusion_tb.sv -----
// ----------------------------------------------------------------------------
// imu_quaternion_gravity_fusion_tb: stimulus and verdict for the fusion block
// Drives directed and random IMU samples in bursts under several gain
// settings while the receiver stalls; the checker scores every result.
// ----------------------------------------------------------------------------
module imu_quaternion_gravity_fusion_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [215:0] s_tdata;     // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, time_step
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;     // world_x, world_y, world_z
	logic         cfg_we;
	logic [15:0]  cfg_wdata;
	int           fail_count;
	int           pending;
	int           burst_left;
	int           stall_cnt;

	imu_quaternion_gravity_fusion dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	imu_quaternion_gravity_fusion_chk chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// receiver: random acceptance, random stalls and long holds
	always @(negedge clk) begin
		if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < 3) begin
			stall_cnt <= $urandom_range(1, 600);
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// one input transfer; valid stays high inside a burst, drops for a gap
	task automatic send_sample(input logic [215:0] d);
		@(negedge clk);
		s_tdata <= d;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 40)) @(negedge clk);
			burst_left = $urandom_range(0, 8);
		end
	endtask

	// wait out every pending result, then let the datapath settle
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_gain(input logic [15:0] v);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [215:0] pack(input logic [31:0] gx, input logic [31:0] gy,
			input logic [31:0] gz, input logic [31:0] ax, input logic [31:0] ay,
			input logic [31:0] az, input logic [23:0] dt);
		return {dt, az, ay, ax, gz, gy, gx};
	endfunction

	// mostly plausible motion, some full-range noise
	function automatic logic [215:0] rand_sample();
		logic [31:0] f [6];
		logic [23:0] dt;
		if ($urandom_range(0, 9) < 8) begin
			for (int i = 0; i < 3; i++)
				f[i] = 32'($signed($urandom_range(0, 2 * 2000 * 65536)) - 2000 * 65536);
			for (int i = 3; i < 6; i++)
				f[i] = 32'($signed($urandom_range(0, 2 * 4 * 65536)) - 4 * 65536);
			dt = 24'($urandom_range(0, 200000));
		end else begin
			for (int i = 0; i < 6; i++) f[i] = $urandom;
			dt = 24'($urandom);
		end
		return pack(f[0], f[1], f[2], f[3], f[4], f[5], dt);
	endfunction

	localparam logic [31:0] MaxS = 32'h7fffffff;
	localparam logic [31:0] MinS = 32'h80000000;
	localparam logic [31:0] OneG = 32'h00010000;

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		burst_left = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: default gain, then the extremes
		send_sample(pack(0, 0, 0, 0, 0, OneG, 24'd16777));
		send_sample(pack(0, 0, 0, 0, 0, 0, 24'd16777));          // zero accel
		send_sample(pack(0, 0, 0, 0, 0, 0, 24'd0));
		send_sample(pack(32'd90 << 16, 0, 0, 0, OneG, 0, 24'd16777));
		write_gain(16'd65535);
		send_sample(pack(MaxS, MaxS, MaxS, MaxS, MaxS, MaxS, 24'hffffff)); // delta overflow
		send_sample(pack(MinS, MinS, MinS, MinS, MinS, MinS, 24'hffffff));
		send_sample(pack(MaxS, MinS, 0, MinS, MaxS, 0, 24'hffffff));
		send_sample(pack(0, 0, 0, OneG, 0, 0, 24'd1));
		send_sample(pack(32'hffffffff, 1, 32'hffffffff, 1, 32'hffffffff, 1, 24'd1));
		write_gain(16'd0);
		send_sample(pack(0, 32'd200 << 16, 0, 0, OneG, OneG, 24'd100000));
		send_sample(pack(0, 0, MinS, MaxS, 0, 0, 24'hffffff));
		send_sample(pack(0, 0, 0, 0, 0, 0, 24'hffffff));
		write_gain(16'd1311);
		send_sample(pack(MaxS, 0, 0, 0, 0, MinS, 24'h800000));
		send_sample(pack(0, MaxS, 0, 0, 0, 32'hfff00000, 24'h7fffff));

		// random phases with a fresh gain each
		for (int ph = 0; ph < 5; ph++) begin
			write_gain((ph == 1) ? 16'd65535 : (ph == 3) ? 16'd0 : 16'($urandom));
			for (int k = 0; k < 100; k++) begin
				send_sample(rand_sample());
				if (k == 50)
					drain();
			end
		end

		drain();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#30ms;
		$display("Verification failed");
		$finish;
	end

endmodule
